// ===== rtl/bda_pkg.sv =====
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the button debounce block
// Holds field widths, configuration register indexes and the lane control type.
// ----------------------------------------------------------------------------
package bda_pkg;

   localparam int TIME_W          = 32;
   localparam int THR_W           = 4;
   localparam int TIMEOUT_W       = 8;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 8;
   localparam int MS_PER_UNIT     = 5000;
   // 255 * 5000 = 1275000 fits in 21 bits.
   localparam int WINDOW_W        = 21;
   localparam logic [THR_W-1:0] RESET_THRESHOLD = THR_W'(4);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESS_THRESHOLD   = 2'd0,
      CSR_RELEASE_THRESHOLD = 2'd1,
      CSR_SLEEP_TIMEOUT     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             step;
      logic             wake;
      logic [THR_W-1:0] press_threshold;
      logic [THR_W-1:0] release_threshold;
   } lane_ctrl_type;

endpackage

// ===== rtl/bda_if.sv =====
// ----------------------------------------------------------------------------
// bda_if: valid/ready channels of the button debounce block
// Request channel carries one sample or wake item, response channel one result.
// ----------------------------------------------------------------------------
interface bda_req_if #(parameter int NUM_BUTTONS = 3) ();
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [NUM_BUTTONS-1:0] pin_levels;
   logic [31:0]            now_ms;

   modport source (output valid, kind, pin_levels, now_ms, input ready);
   modport sink   (input valid, kind, pin_levels, now_ms, output ready);
endinterface

interface bda_rsp_if #(parameter int NUM_BUTTONS = 3) ();
   logic                   valid;
   logic                   ready;
   logic [NUM_BUTTONS-1:0] press_events;
   logic [NUM_BUTTONS-1:0] held_flags;
   logic                   active;

   modport source (output valid, press_events, held_flags, active, input ready);
   modport sink   (input valid, press_events, held_flags, active, output ready);
endinterface

// ===== rtl/button_debounce_activity_core.sv =====
// Path: a request transfer passes the input register, then the result register,
// and waits while the response is stalled. Every lane updates in the same cycle.
// Throughput: one item per cycle unless the response is stalled.
// Reset: synchronous, active high; clears histories, flags, press times and
// the pipeline valids, and loads both thresholds with 4 and the timeout with 0.
// ----------------------------------------------------------------------------
// button_debounce_activity_core: debounced buttons with activity report
// Shift-register popcount debouncer with one-shot press events, a wake
// command and a sleep-timeout activity flag.
// ----------------------------------------------------------------------------
module button_debounce_activity_core #(
   parameter int NUM_BUTTONS  = 3,
   parameter int HISTORY_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   bda_req_if.sink                             req_if,
   bda_rsp_if.source                           rsp_if,
   input  logic                                csr_we,
   input  logic [bda_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bda_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bda_pkg::*;

   // Configuration registers. The user must make writes only while the block is idle;
   // the block itself does not enforce this. The datapath reads them without any hold-off.
   logic [THR_W-1:0]     press_thr_ff, press_thr_in;
   logic [THR_W-1:0]     release_thr_ff, release_thr_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;

   always_comb begin
      press_thr_in   = press_thr_ff;
      release_thr_in = release_thr_ff;
      timeout_in     = timeout_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PRESS_THRESHOLD:   press_thr_in   = csr_wdata[THR_W-1:0];
            CSR_RELEASE_THRESHOLD: release_thr_in = csr_wdata[THR_W-1:0];
            CSR_SLEEP_TIMEOUT:     timeout_in     = csr_wdata[TIMEOUT_W-1:0];
            default: begin
               // Unmapped index: the write is dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_thr_ff   <= RESET_THRESHOLD;
         release_thr_ff <= RESET_THRESHOLD;
         timeout_ff     <= '0;
      end else begin
         press_thr_ff   <= press_thr_in;
         release_thr_ff <= release_thr_in;
         timeout_ff     <= timeout_in;
      end
   end

   // Handshake. The result register frees up when it is empty or its
   // transfer completes this cycle; the input register then moves forward,
   // and the input register takes a new item whenever it is empty or moving.
   logic                   in_valid_ff, in_valid_in;
   logic                   in_kind_ff;
   logic [NUM_BUTTONS-1:0] in_pins_ff;
   logic [TIME_W-1:0]      in_now_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [NUM_BUTTONS-1:0] out_events_ff;
   logic [NUM_BUTTONS-1:0] out_held_ff;
   logic                   out_active_ff;

   logic out_free;
   logic advance;
   logic req_take;

   assign out_free  = !out_valid_ff || rsp_if.ready;
   assign advance   = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || out_free;
   assign req_take  = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_if.kind;
         in_pins_ff <= req_if.pin_levels;
         in_now_ff  <= req_if.now_ms;
      end
   end

   // One lane per button. Each lane updates its state on the cycle the item
   // moves into the result register, so a following item sees it at once.
   lane_ctrl_type                          lane_ctrl;
   logic [NUM_BUTTONS-1:0]                 events_c;
   logic [NUM_BUTTONS-1:0]                 held_c;
   logic [NUM_BUTTONS-1:0][TIME_W-1:0]     press_times_c;
   logic                                   active_c;

   always_comb begin
      lane_ctrl.step              = advance;
      lane_ctrl.wake              = in_kind_ff;
      lane_ctrl.press_threshold   = press_thr_ff;
      lane_ctrl.release_threshold = release_thr_ff;
   end

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
      bda_button_lane #(
         .HISTORY_BITS (HISTORY_BITS)
      ) u_lane (
         .clock           (clock),
         .reset           (reset),
         .ctrl            (lane_ctrl),
         .pin_level       (in_pins_ff[g]),
         .now_ms          (in_now_ff),
         .press_event     (events_c[g]),
         .held            (held_c[g]),
         .press_time_next (press_times_c[g])
      );
   end

   // Activity uses the press times as they stand after this item. The window
   // register follows the timeout's next value so it changes with the timeout.
   bda_activity #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_activity (
      .clock         (clock),
      .reset         (reset),
      .sleep_timeout (timeout_in),
      .now_ms        (in_now_ff),
      .press_times   (press_times_c),
      .active        (active_c)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         out_events_ff <= events_c;
         out_held_ff   <= held_c;
         out_active_ff <= active_c;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.press_events = out_events_ff;
   assign rsp_if.held_flags   = out_held_ff;
   assign rsp_if.active       = out_active_ff;

endmodule

// ===== rtl/bda_button_lane.sv =====
// ----------------------------------------------------------------------------
// bda_button_lane: debounce state of one button
// Shift history, count set bits, fire the one-shot press and re-arm on release.
// ----------------------------------------------------------------------------
module bda_button_lane #(
   parameter int HISTORY_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bda_pkg::lane_ctrl_type        ctrl,
   input  logic                          pin_level,
   input  logic [bda_pkg::TIME_W-1:0]    now_ms,
   output logic                          press_event,
   output logic                          held,
   output logic [bda_pkg::TIME_W-1:0]    press_time_next
);
   import bda_pkg::*;

   localparam int CNT_W = $clog2(HISTORY_BITS + 1);
   localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

   logic [HISTORY_BITS-1:0] history_ff, history_in;
   logic                    processed_ff, processed_in;
   logic                    fired_ff, fired_in;
   logic [TIME_W-1:0]       press_time_ff, press_time_in;

   logic [HISTORY_BITS-1:0]       shifted;
   logic [CNT_W-1:0]              ones;
   logic [CMP_W-1:0]              ones_ext;
   logic [HISTORY_BITS+THR_W-1:0] thr_ext;
   logic                          pressed;
   logic                          event_c;

   assign pressed = ~pin_level;
   assign shifted = {history_ff[HISTORY_BITS-2:0], pressed};
   assign thr_ext = {{HISTORY_BITS{1'b0}}, ctrl.press_threshold};

   always_comb begin
      ones = '0;
      for (int b = 0; b < HISTORY_BITS; b++) begin
         ones = ones + CNT_W'(shifted[b]);
      end
   end

   assign ones_ext = CMP_W'(ones);

   always_comb begin
      history_in    = history_ff;
      processed_in  = processed_ff;
      fired_in      = fired_ff;
      press_time_in = press_time_ff;
      event_c       = 1'b0;
      if (ctrl.step) begin
         if (ctrl.wake) begin
            history_in    = thr_ext[HISTORY_BITS-1:0];
            processed_in  = 1'b1;
            fired_in      = 1'b1;
            press_time_in = now_ms;
         end else begin
            history_in = shifted;
            if (pressed) begin
               if (ones_ext >= CMP_W'(ctrl.press_threshold)) begin
                  if (!processed_ff) begin
                     press_time_in = now_ms;
                     processed_in  = 1'b1;
                  end
                  if (!fired_ff) begin
                     fired_in = 1'b1;
                     event_c  = 1'b1;
                  end
               end
            end else if (ones_ext <= CMP_W'(ctrl.release_threshold)) begin
               processed_in = 1'b0;
               fired_in     = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff    <= '0;
         processed_ff  <= 1'b0;
         fired_ff      <= 1'b0;
         press_time_ff <= '0;
      end else begin
         history_ff    <= history_in;
         processed_ff  <= processed_in;
         fired_ff      <= fired_in;
         press_time_ff <= press_time_in;
      end
   end

   assign press_event     = event_c;
   assign held            = fired_in;
   assign press_time_next = press_time_in;

endmodule

// ===== rtl/bda_activity.sv =====
// ----------------------------------------------------------------------------
// bda_activity: activity window check
// Holds the window in milliseconds and compares elapsed time per button.
// ----------------------------------------------------------------------------
module bda_activity #(
   parameter int NUM_BUTTONS = 3
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [bda_pkg::TIMEOUT_W-1:0]                 sleep_timeout,
   input  logic [bda_pkg::TIME_W-1:0]                    now_ms,
   input  logic [NUM_BUTTONS-1:0][bda_pkg::TIME_W-1:0]   press_times,
   output logic                                          active
);
   import bda_pkg::*;

   logic [WINDOW_W-1:0] window_ff, window_in;
   logic [NUM_BUTTONS-1:0] recent;

   // Window is a constant multiple of the timeout. It is loaded from the
   // timeout register's next value, so both change at the same edge.
   assign window_in = WINDOW_W'(sleep_timeout) * WINDOW_W'(MS_PER_UNIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         recent[i] = (now_ms - press_times[i]) < TIME_W'(window_ff);
      end
   end

   // A zero window only comes from a zero timeout, which means always active.
   assign active = (window_ff == '0) || (|recent);

endmodule

// ===== rtl/bda_checker.sv =====
// ----------------------------------------------------------------------------
// bda_checker: port-level checks for the button debounce block
// Watches the request and response channels and the reset.
// ----------------------------------------------------------------------------
module bda_checker #(
   parameter int NUM_BUTTONS = 3
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [NUM_BUTTONS-1:0] rsp_press_events,
   input logic [NUM_BUTTONS-1:0] rsp_held_flags
);

   // A pending response stays up until its transfer completes.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped before transfer");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A button that fires its press is held in the same result.
   a_event_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_press_events & ~rsp_held_flags) == '0))
      else $error("press event without held flag");

   // A fresh response is always preceded by a request transfer.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without request transfer");

endmodule

bind button_debounce_activity_core bda_checker #(
   .NUM_BUTTONS (NUM_BUTTONS)
) u_bda_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_press_events (rsp_if.press_events),
   .rsp_held_flags   (rsp_if.held_flags)
);

// ===== bench/tb_button_debounce_activity_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_activity_core: self-checking bench for the button debouncer
// A short scripted sequence covers the thresholds, the wake command and the
// activity window. Phases of random press and bounce sequences follow, each
// under fresh register settings. Every result is checked against the result typed
// into its script row or else a cycle-free model of the debouncer in this file.
// ----------------------------------------------------------------------------
module tb_button_debounce_activity_core;
   import bda_pkg::*;

   localparam int NB = 3;
   localparam int HB = 8;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_WAKE   = 1'b1;

   localparam logic [31:0] MS_PER_TIMEOUT_UNIT = 32'd5000;

   localparam int SCRIPT_ROWS     = 31;
   localparam int RANDOM_PHASES   = 13;
   localparam int PHASE_ITEMS     = 100;
   localparam int DRAIN_CYCLES    = 4;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_AFTER      = 300;
   localparam int LONG_HOLD       = 120;
   localparam int MAX_REPORTED    = 10;
   localparam int WATCHDOG_CYCLES = 400000;

   typedef struct packed {
      logic          kind;
      logic [NB-1:0] pin_levels;
      logic [31:0]   now_ms;
   } pin_sample_type;

   typedef struct packed {
      logic [NB-1:0] press_events;
      logic [NB-1:0] held_flags;
      logic          active;
   } button_report_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_op_type;

   // One line of the scripted sequence: either a register write or a sample
   // transfer, the latter optionally with its result typed in by hand.
   typedef struct packed {
      row_op_type            op;
      csr_index_type         csr_index;
      logic [CSR_DATA_W-1:0] csr_data;
      pin_sample_type        sample;
      logic                  fixed;
      button_report_type     report;
   } script_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bda_req_if #(.NUM_BUTTONS(NB)) req_ch ();
   bda_rsp_if #(.NUM_BUTTONS(NB)) rsp_ch ();

   button_debounce_activity_core #(
      .NUM_BUTTONS  (NB),
      .HISTORY_BITS (HB)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the debouncer state and its registers.
   logic [HB-1:0]        shadow_history    [NB];
   logic                 shadow_processed  [NB];
   logic                 shadow_fired      [NB];
   logic [31:0]          shadow_press_time [NB];
   logic [THR_W-1:0]     shadow_press_thr;
   logic [THR_W-1:0]     shadow_release_thr;
   logic [TIMEOUT_W-1:0] shadow_sleep_units;

   button_report_type report_q [$];
   script_row_type    directed_script [0:SCRIPT_ROWS-1];

   logic idle_on;
   int   cycle_count;
   int   items_sent;
   int   wakes_sent;
   int   reports_seen;
   int   events_seen;
   int   fault_count;

   // The clock toggles every nanosecond, giving a 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: a run that outlives the limit has lost a transfer somewhere.
   initial begin
      cycle_count = 0;
      wait (cycle_count >= WATCHDOG_CYCLES);
      $display("tb_button_debounce_activity_core: errors");
      $finish;
   end

   // Advances the shadow state by one transfer and returns the result that
   // the block should produce for it.
   function automatic button_report_type debounce_step(pin_sample_type s);
      button_report_type r;
      logic [HB-1:0]  h;
      logic           pressed;
      logic [31:0]    window;
      logic [31:0]    elapsed;
      r = '0;
      for (int b = 0; b < NB; b++) begin
         if (s.kind == KIND_WAKE) begin
            // Wake makes every button look handled and freshly pressed.
            shadow_fired[b]      = 1'b1;
            shadow_processed[b]  = 1'b1;
            shadow_history[b]    = HB'(shadow_press_thr);
            shadow_press_time[b] = s.now_ms;
         end else begin
            pressed           = ~s.pin_levels[b];
            h                 = {shadow_history[b][HB-2:0], pressed};
            shadow_history[b] = h;
            if (pressed) begin
               if ($countones(h) >= shadow_press_thr) begin
                  if (!shadow_processed[b]) begin
                     shadow_press_time[b] = s.now_ms;
                     shadow_processed[b]  = 1'b1;
                  end
                  if (!shadow_fired[b]) begin
                     shadow_fired[b]   = 1'b1;
                     r.press_events[b] = 1'b1;
                  end
               end
            end else if ($countones(h) <= shadow_release_thr) begin
               shadow_processed[b] = 1'b0;
               shadow_fired[b]     = 1'b0;
            end
         end
         r.held_flags[b] = shadow_fired[b];
      end
      // The window test uses wrapping time differences and the state after
      // this transfer; a zero timeout keeps the block active for good.
      if (shadow_sleep_units == '0) begin
         r.active = 1'b1;
      end else begin
         window = 32'(shadow_sleep_units) * MS_PER_TIMEOUT_UNIT;
         for (int b = 0; b < NB; b++) begin
            elapsed = s.now_ms - shadow_press_time[b];
            if (elapsed < window) begin
               r.active = 1'b1;
            end
         end
      end
      return r;
   endfunction

   function automatic script_row_type csr_row(csr_index_type idx,
                                              logic [CSR_DATA_W-1:0] data);
      script_row_type row;
      row           = '0;
      row.op        = ROW_CSR;
      row.csr_index = idx;
      row.csr_data  = data;
      return row;
   endfunction

   function automatic script_row_type item_row(logic kind, logic [NB-1:0] pins,
                                               logic [31:0] now_ms);
      script_row_type row;
      row                   = '0;
      row.op                = ROW_ITEM;
      row.sample.kind       = kind;
      row.sample.pin_levels = pins;
      row.sample.now_ms     = now_ms;
      return row;
   endfunction

   function automatic script_row_type fixed_row(logic kind, logic [NB-1:0] pins,
                                                logic [31:0] now_ms,
                                                logic [NB-1:0] events,
                                                logic [NB-1:0] held,
                                                logic active);
      script_row_type row;
      row                     = item_row(kind, pins, now_ms);
      row.fixed               = 1'b1;
      row.report.press_events = events;
      row.report.held_flags   = held;
      row.report.active       = active;
      return row;
   endfunction

   // Register writes happen only with the block empty: the sender goes quiet,
   // every expected result must have come back, and the pipeline gets a few
   // more cycles before the write is presented. The write enable is left
   // high after the capturing edge; whoever acts next lowers it.
   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      req_ch.valid <= 1'b0;
      csr_we       <= 1'b0;
      while (report_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_PRESS_THRESHOLD:   shadow_press_thr   = data[THR_W-1:0];
         CSR_RELEASE_THRESHOLD: shadow_release_thr = data[THR_W-1:0];
         CSR_SLEEP_TIMEOUT:     shadow_sleep_units = data[TIMEOUT_W-1:0];
         default: ;
      endcase
   endtask

   // Offers one sample, possibly after an idle burst, and waits for the
   // transfer. Valid stays high on return so that back-to-back items need
   // no second assignment in the same step.
   task automatic send_item(pin_sample_type s, logic use_fixed,
                            button_report_type fixed_report);
      button_report_type predicted;
      csr_we <= 1'b0;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= s.kind;
      req_ch.pin_levels <= s.pin_levels;
      req_ch.now_ms     <= s.now_ms;
      do @(posedge clock); while (!req_ch.ready);
      predicted = debounce_step(s);
      report_q.push_back(use_fixed ? fixed_report : predicted);
      items_sent++;
      if (s.kind == KIND_WAKE) begin
         wakes_sent++;
      end
   endtask

   // Result side: random stalls, plus one long hold-off once a few hundred
   // results are in, so that the block backs up into its input.
   initial begin : result_sink
      int   hold_cycles;
      logic long_hold_done;
      long_hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!long_hold_done && reports_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++) begin
               @(posedge clock);
            end
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Every result transfer is matched against the oldest expectation.
   always @(posedge clock) begin : result_check
      button_report_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         reports_seen++;
         events_seen += $countones(rsp_ch.press_events);
         if (report_q.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTED) begin
               $display("%0t: result with nothing outstanding: events %b held %b active %b",
                        $time, rsp_ch.press_events, rsp_ch.held_flags, rsp_ch.active);
            end
         end else begin
            want = report_q.pop_front();
            if (rsp_ch.press_events !== want.press_events ||
                rsp_ch.held_flags !== want.held_flags ||
                rsp_ch.active !== want.active) begin
               fault_count++;
               if (fault_count <= MAX_REPORTED) begin
                  $display("%0t: result %0d mismatch: events %b/%b held %b/%b active %b/%b",
                           $time, reports_seen, rsp_ch.press_events, want.press_events,
                           rsp_ch.held_flags, want.held_flags, rsp_ch.active, want.active);
               end
            end
         end
      end
   end

   initial begin
      int                    phase;
      int                    bounce_bit;
      pin_sample_type        s;
      logic [NB-1:0]         btn_level;
      logic [31:0]           now_cursor;
      logic [THR_W-1:0]      press_pick;
      logic [THR_W-1:0]      release_pick;
      logic [TIMEOUT_W-1:0]  sleep_pick;

      items_sent   = 0;
      wakes_sent   = 0;
      reports_seen = 0;
      events_seen  = 0;
      fault_count  = 0;
      idle_on      = 1'b1;

      // The shadow starts out the way reset leaves the block.
      for (int b = 0; b < NB; b++) begin
         shadow_history[b]    = '0;
         shadow_processed[b]  = 1'b0;
         shadow_fired[b]      = 1'b0;
         shadow_press_time[b] = '0;
      end
      shadow_press_thr   = RESET_THRESHOLD;
      shadow_release_thr = RESET_THRESHOLD;
      shadow_sleep_units = '0;

      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.kind       <= KIND_SAMPLE;
      req_ch.pin_levels <= '1;
      req_ch.now_ms     <= '0;

      // Scripted sequence. The first two samples check the activity window
      // against the zero press time left by reset. Four pressed samples then
      // reach the default threshold and fire all buttons once; a wake and
      // the threshold extremes (zero, above the history width, release at
      // the top and at zero) follow, and the last rows sit on the edge of
      // the widest activity window.
      directed_script = '{
         csr_row(CSR_SLEEP_TIMEOUT, 8'd1),
         fixed_row(KIND_SAMPLE, 3'b111, 32'd4999, 3'b000, 3'b000, 1'b1),
         fixed_row(KIND_SAMPLE, 3'b111, 32'd5000, 3'b000, 3'b000, 1'b0),
         csr_row(CSR_SLEEP_TIMEOUT, 8'd0),
         fixed_row(KIND_SAMPLE, 3'b000, 32'd1, 3'b000, 3'b000, 1'b1),
         fixed_row(KIND_SAMPLE, 3'b000, 32'd2, 3'b000, 3'b000, 1'b1),
         fixed_row(KIND_SAMPLE, 3'b000, 32'd3, 3'b000, 3'b000, 1'b1),
         fixed_row(KIND_SAMPLE, 3'b000, 32'd4, 3'b111, 3'b111, 1'b1),
         fixed_row(KIND_SAMPLE, 3'b000, 32'd5, 3'b000, 3'b111, 1'b1),
         fixed_row(KIND_WAKE, 3'b101, 32'hFFFF_FFFF, 3'b000, 3'b111, 1'b1),
         item_row(KIND_SAMPLE, 3'b111, 32'd0),
         item_row(KIND_SAMPLE, 3'b010, 32'h8000_0000),
         item_row(KIND_SAMPLE, 3'b101, 32'd7),
         csr_row(CSR_PRESS_THRESHOLD, 8'd0),
         item_row(KIND_SAMPLE, 3'b110, 32'd100),
         item_row(KIND_SAMPLE, 3'b001, 32'd101),
         csr_row(CSR_PRESS_THRESHOLD, 8'd15),
         csr_row(CSR_RELEASE_THRESHOLD, 8'd15),
         item_row(KIND_SAMPLE, 3'b000, 32'd200),
         item_row(KIND_SAMPLE, 3'b000, 32'd201),
         fixed_row(KIND_WAKE, 3'b000, 32'd300, 3'b000, 3'b111, 1'b1),
         item_row(KIND_SAMPLE, 3'b111, 32'd301),
         csr_row(CSR_RELEASE_THRESHOLD, 8'd0),
         csr_row(CSR_PRESS_THRESHOLD, 8'd8),
         item_row(KIND_SAMPLE, 3'b011, 32'd400),
         csr_row(CSR_SLEEP_TIMEOUT, 8'd255),
         item_row(KIND_SAMPLE, 3'b000, 32'd1275399),
         item_row(KIND_SAMPLE, 3'b111, 32'hFFFF_FFFF),
         fixed_row(KIND_WAKE, 3'b111, 32'h1234_5678, 3'b000, 3'b111, 1'b1),
         item_row(KIND_SAMPLE, 3'b111, 32'h1247_CAEF),
         item_row(KIND_SAMPLE, 3'b000, 32'h1247_CAF0)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         if (directed_script[r].op == ROW_CSR) begin
            write_csr(directed_script[r].csr_index, directed_script[r].csr_data);
         end else begin
            send_item(directed_script[r].sample, directed_script[r].fixed,
                      directed_script[r].report);
         end
      end

      // Random phases. Each button follows a slowly changing level, as a
      // finger would, with the odd bounced sample and some fully random pin
      // patterns mixed in. Time mostly creeps forward in small steps, now
      // and then leaps far enough to leave the activity window, and some
      // phases start just short of the 32-bit wrap.
      btn_level  = '1;
      now_cursor = 32'd1000;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         // One phase in four runs without idling, and so does the last one.
         idle_on = (phase != RANDOM_PHASES - 1) && (phase % 4 != 2);

         press_pick = ($urandom_range(0, 7) == 0) ? THR_W'($urandom_range(0, 15))
                                                  : THR_W'($urandom_range(1, 8));
         release_pick = ($urandom_range(0, 7) == 0) ? THR_W'($urandom_range(0, 15))
                        : THR_W'($urandom_range(0, (press_pick > 1) ? press_pick - 1 : 0));
         case ($urandom_range(0, 4))
            0:       sleep_pick = 8'd0;
            1:       sleep_pick = 8'd1;
            2:       sleep_pick = 8'd2;
            3:       sleep_pick = 8'd255;
            default: sleep_pick = TIMEOUT_W'($urandom_range(0, 255));
         endcase
         write_csr(CSR_PRESS_THRESHOLD, CSR_DATA_W'(press_pick));
         write_csr(CSR_RELEASE_THRESHOLD, CSR_DATA_W'(release_pick));
         write_csr(CSR_SLEEP_TIMEOUT, CSR_DATA_W'(sleep_pick));

         if ($urandom_range(0, 3) == 0) begin
            now_cursor = 32'hFFFF_F000 + $urandom_range(0, 4095);
         end

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            for (int b = 0; b < NB; b++) begin
               if ($urandom_range(0, 11) == 0) begin
                  btn_level[b] = ~btn_level[b];
               end
            end
            s.kind       = ($urandom_range(0, 29) == 0) ? KIND_WAKE : KIND_SAMPLE;
            s.pin_levels = btn_level;
            case ($urandom_range(0, 9))
               0: s.pin_levels = NB'($urandom());
               1, 2: begin
                  bounce_bit = $urandom_range(0, NB - 1);
                  s.pin_levels[bounce_bit] = ~s.pin_levels[bounce_bit];
               end
               default: ;
            endcase
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: now_cursor = now_cursor + $urandom_range(1, 20);
               7, 8:                now_cursor = now_cursor + $urandom_range(500, 20000);
               default:             now_cursor = $urandom();
            endcase
            s.now_ms = now_cursor;
            send_item(s, 1'b0, '0);
         end
      end

      // Let the last results drain, then let the pipeline sit idle for a settle wait
      // to show any stray transfer.
      req_ch.valid <= 1'b0;
      while (report_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d sample transfers (%0d wakes) over %0d register phases.",
               items_sent, wakes_sent, RANDOM_PHASES + 1);
      $display("Checked %0d results carrying %0d press events; %0d mismatches.",
               reports_seen, events_seen, fault_count);
      if (fault_count == 0 && report_q.size() == 0) begin
         $display("tb_button_debounce_activity_core: clean");
      end else begin
         $display("tb_button_debounce_activity_core: errors");
      end
      $finish;
   end

endmodule
